// ----- design/pid_aw_pkg.sv -----
package pid_aw_pkg;

    // register indexes of the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER = 3'd5;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MUL_W  = DATA_W + 1;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned FRAC_W = 16;

    // divider steps, one quotient bit each
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic [DATA_W-1:0]        step_time;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     zero_step;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_P_TERM,
        ST_INC,
        ST_ACC,
        ST_MUL_I,
        ST_I_TERM,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DIV_FIN,
        ST_SUM,
        ST_DONE
    } state_t;

    // saturate a wide signed value to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > PROD_W'(Q_MAX))
            r = Q_MAX;
        else if (v < PROD_W'(Q_MIN))
            r = Q_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // q16.16 product rescale: floor shift then saturate
    function automatic logic signed [DATA_W-1:0] satq(input logic signed [PROD_W-1:0] v);
        return sat32(v >>> FRAC_W);
    endfunction

endpackage

// ----- design/pid_controller_antiwindup.sv -----
// pid controller with integrator clamping, signed q16.16
//
// input channel in_valid/in_ready carries one transaction per sample:
// measured value and step time. output channel out_valid/out_ready
// returns one transaction per sample: the clamped drive and a flag
// that is set when the step time was zero (derivative forced to zero).
// gains, target and output limits are written through cfg_en,
// cfg_index and cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. unknown indexes are ignored.
//
// one shared 33x33 signed multiplier is used four times in turn, and
// the derivative divide runs one quotient bit per cycle; it is skipped
// when the step time is zero or the quotient saturates. a new sample
// is accepted only in the idle state, after the previous one is done.
// the result sits in an output register; a new sample can be accepted
// while it waits, and a finished sample holds until that slot is free.
// reset clears the state, the output valid flag, the configuration
// registers, the step counter, the integral accumulator and the
// previous error to zero.
module pid_controller_antiwindup (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pid_aw_pkg::in_t       in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pid_aw_pkg::out_t      out_data,
    input  logic                  cfg_en,
    input  logic [pid_aw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pid_aw_pkg::DATA_W-1:0]    cfg_data
);

    localparam int unsigned W  = pid_aw_pkg::DATA_W;
    localparam int unsigned PW = pid_aw_pkg::PROD_W;
    localparam int unsigned MW = pid_aw_pkg::MUL_W;

    pid_aw_pkg::state_t state_reg, state_next;

    // configuration
    logic signed [W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [W-1:0] target_reg, out_upper_reg, out_lower_reg;

    // persistent state
    logic signed [W-1:0] accum_reg, last_error_reg;

    // working registers of one sample
    logic signed [W-1:0]  meas_reg;
    logic [W-1:0]         dt_reg;
    logic signed [W-1:0]  err_reg, diff_reg, p_reg, inc_reg;
    logic signed [W-1:0]  imax_reg, imin_reg, iterm_reg, dterm_reg, drive_reg;
    logic signed [PW-1:0] prod_reg;
    logic [W-1:0]         rem_reg, quo_reg, lo_reg;
    logic                 neg_reg;
    logic [pid_aw_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic                 out_valid_reg;
    pid_aw_pkg::out_t     out_reg;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_y;

    // combinational helpers
    logic                 in_fire, out_free;
    logic signed [W-1:0]  acc_sum;
    logic [2*W-1:0]       mag;
    logic [W:0]           shifted;
    logic                 q_bit;
    logic [W:0]           q_wide;
    logic signed [W+1:0]  sum3;
    logic signed [W-1:0]  sum_sat;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign mul_y = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pid_aw_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = pid_aw_pkg::ST_ERR;
            end
            pid_aw_pkg::ST_ERR:      state_next = pid_aw_pkg::ST_MUL_P;
            pid_aw_pkg::ST_MUL_P:    state_next = pid_aw_pkg::ST_P_TERM;
            pid_aw_pkg::ST_P_TERM:   state_next = pid_aw_pkg::ST_INC;
            pid_aw_pkg::ST_INC:      state_next = pid_aw_pkg::ST_ACC;
            pid_aw_pkg::ST_ACC:      state_next = pid_aw_pkg::ST_MUL_I;
            pid_aw_pkg::ST_MUL_I:    state_next = pid_aw_pkg::ST_I_TERM;
            pid_aw_pkg::ST_I_TERM:   state_next = pid_aw_pkg::ST_DIV_SETUP;
            pid_aw_pkg::ST_DIV_SETUP:
            begin
                if (dt_reg == '0 || mag[2*W-1:W] >= dt_reg)
                    state_next = pid_aw_pkg::ST_SUM;
                else
                    state_next = pid_aw_pkg::ST_DIV;
            end
            pid_aw_pkg::ST_DIV:
            begin
                if (cnt_reg == pid_aw_pkg::DIV_LAST)
                    state_next = pid_aw_pkg::ST_DIV_FIN;
            end
            pid_aw_pkg::ST_DIV_FIN:  state_next = pid_aw_pkg::ST_SUM;
            pid_aw_pkg::ST_SUM:      state_next = pid_aw_pkg::ST_DONE;
            pid_aw_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = pid_aw_pkg::ST_IDLE;
            end
            default:                 state_next = pid_aw_pkg::ST_IDLE;
        endcase
    end

    // control outputs: handshake and multiplier operand select
    always_comb
    begin
        in_ready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            pid_aw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            pid_aw_pkg::ST_MUL_P:
            begin
                mul_a = MW'(gain_p_reg);
                mul_b = MW'(err_reg);
            end
            pid_aw_pkg::ST_P_TERM:
            begin
                mul_a = MW'(err_reg);
                mul_b = {1'b0, dt_reg};
            end
            pid_aw_pkg::ST_MUL_I:
            begin
                mul_a = MW'(gain_i_reg);
                mul_b = MW'(accum_reg);
            end
            pid_aw_pkg::ST_I_TERM:
            begin
                mul_a = MW'(gain_d_reg);
                mul_b = MW'(diff_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath helpers
    always_comb
    begin
        acc_sum = pid_aw_pkg::sat32(PW'(accum_reg) + PW'(inc_reg));
        mag     = prod_reg[PW-1] ? (2*W)'(-prod_reg) : prod_reg[2*W-1:0];
        shifted = {rem_reg, lo_reg[W-1]};
        q_bit   = (shifted >= {1'b0, dt_reg});
        q_wide  = {1'b0, quo_reg};
        sum3    = (W+2)'(p_reg) + (W+2)'(iterm_reg) + (W+2)'(dterm_reg);
        sum_sat = pid_aw_pkg::sat32(PW'(sum3));
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pid_aw_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            target_reg     <= '0;
            out_upper_reg  <= '0;
            out_lower_reg  <= '0;
            accum_reg      <= '0;
            last_error_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_en)
            begin
                unique case (cfg_index)
                    pid_aw_pkg::REG_GAIN_P:    gain_p_reg    <= cfg_data;
                    pid_aw_pkg::REG_GAIN_I:    gain_i_reg    <= cfg_data;
                    pid_aw_pkg::REG_GAIN_D:    gain_d_reg    <= cfg_data;
                    pid_aw_pkg::REG_TARGET:    target_reg    <= cfg_data;
                    pid_aw_pkg::REG_OUT_UPPER: out_upper_reg <= cfg_data;
                    pid_aw_pkg::REG_OUT_LOWER: out_lower_reg <= cfg_data;
                    default:                   ;
                endcase
            end

            // integrator update with clamping, previous error update
            if (state_reg == pid_aw_pkg::ST_ACC)
            begin
                if (acc_sum > imax_reg)
                    accum_reg <= imax_reg;
                else if (acc_sum < imin_reg)
                    accum_reg <= imin_reg;
                else
                    accum_reg <= acc_sum;
                last_error_reg <= err_reg;
            end

            // divider step counter
            if (state_reg == pid_aw_pkg::ST_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;

            // output slot
            if (state_reg == pid_aw_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            meas_reg <= in_data.measured;
            dt_reg   <= in_data.step_time;
        end

        unique case (state_reg)
            pid_aw_pkg::ST_ERR:
            begin
                err_reg <= pid_aw_pkg::sat32(PW'(target_reg) - PW'(meas_reg));
            end
            pid_aw_pkg::ST_MUL_P:
            begin
                prod_reg <= mul_y;
                diff_reg <= pid_aw_pkg::sat32(PW'(err_reg) - PW'(last_error_reg));
            end
            pid_aw_pkg::ST_P_TERM:
            begin
                p_reg    <= pid_aw_pkg::satq(prod_reg);
                prod_reg <= mul_y;
            end
            pid_aw_pkg::ST_INC:
            begin
                // error times step time, and integrator limits from the p term
                inc_reg <= pid_aw_pkg::satq(prod_reg);
                if (out_upper_reg > p_reg)
                    imax_reg <= pid_aw_pkg::sat32(PW'(out_upper_reg) - PW'(p_reg));
                else
                    imax_reg <= '0;
                if (out_lower_reg < p_reg)
                    imin_reg <= pid_aw_pkg::sat32(PW'(out_lower_reg) - PW'(p_reg));
                else
                    imin_reg <= '0;
            end
            pid_aw_pkg::ST_MUL_I:
            begin
                prod_reg <= mul_y;
            end
            pid_aw_pkg::ST_I_TERM:
            begin
                iterm_reg <= pid_aw_pkg::satq(prod_reg);
                prod_reg  <= mul_y;
            end
            pid_aw_pkg::ST_DIV_SETUP:
            begin
                // zero step, quotient overflow, or start of long division
                neg_reg <= prod_reg[PW-1];
                rem_reg <= mag[2*W-1:W];
                lo_reg  <= mag[W-1:0];
                quo_reg <= '0;
                if (dt_reg == '0)
                    dterm_reg <= '0;
                else if (mag[2*W-1:W] >= dt_reg)
                    dterm_reg <= prod_reg[PW-1] ? pid_aw_pkg::Q_MIN : pid_aw_pkg::Q_MAX;
            end
            pid_aw_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (q_bit)
                    rem_reg <= W'(shifted - {1'b0, dt_reg});
                else
                    rem_reg <= shifted[W-1:0];
                lo_reg  <= {lo_reg[W-2:0], 1'b0};
                quo_reg <= {quo_reg[W-2:0], q_bit};
            end
            pid_aw_pkg::ST_DIV_FIN:
            begin
                // apply sign and saturate the quotient
                if (neg_reg)
                begin
                    if (q_wide > (W+1)'(33'h0_8000_0000))
                        dterm_reg <= pid_aw_pkg::Q_MIN;
                    else
                        dterm_reg <= W'(-q_wide);
                end
                else
                begin
                    if (q_wide > (W+1)'(33'h0_7FFF_FFFF))
                        dterm_reg <= pid_aw_pkg::Q_MAX;
                    else
                        dterm_reg <= quo_reg;
                end
            end
            pid_aw_pkg::ST_SUM:
            begin
                // sum of terms, clamped to the output bounds
                if (sum_sat > out_upper_reg)
                    drive_reg <= out_upper_reg;
                else if (sum_sat < out_lower_reg)
                    drive_reg <= out_lower_reg;
                else
                    drive_reg <= sum_sat;
            end
            pid_aw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_reg.drive     <= drive_reg;
                    out_reg.zero_step <= (dt_reg == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
